// ===== hw/rtl/dds_tuning_word_loader_defines.svh =====
// Assertion helpers shared by the loader modules.
`ifndef DDS_TUNING_WORD_LOADER_DEFINES_SVH
`define DDS_TUNING_WORD_LOADER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTWL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTWL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dtwl_pkg.sv =====
package dtwl_pkg;

   localparam int FREQ_W    = 28;
   localparam int WORD_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int DIV_STEPS = WORD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int IDX_W     = 4;

   localparam logic [FREQ_W-1:0] REF_CLOCK_RESET = FREQ_W'(125000000);
   localparam logic [BYTE_W-1:0] POWER_DOWN_BYTE = 8'h04;

   localparam logic CSR_REF_CLOCK   = 1'b0;
   localparam logic CSR_DEVICE_TYPE = 1'b1;

   typedef enum logic [1:0] {
      MODE_SET_FREQ   = 2'd0,
      MODE_POWER_DOWN = 2'd1,
      MODE_WAKE_UP    = 2'd2,
      MODE_RESET_SEQ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_UPDATE = 2'd1,
      KIND_RESET  = 2'd2,
      KIND_WCLK   = 2'd3
   } kind_type;

   // Where the byte of an output word comes from.
   typedef enum logic [2:0] {
      BSEL_ZERO = 3'd0,
      BSEL_W0   = 3'd1,
      BSEL_W1   = 3'd2,
      BSEL_W2   = 3'd3,
      BSEL_W3   = 3'd4,
      BSEL_CTRL = 3'd5,
      BSEL_PWDN = 3'd6
   } bsel_type;

   typedef struct packed {
      kind_type kind;
      bsel_type bsel;
      logic     last;
   } item_type;

   typedef struct packed {
      logic     capture;
      logic     div_step;
      logic     emit;
      item_type item;
   } cmd_type;

   typedef struct packed {
      logic sat;
      logic out_free;
   } sts_type;

   // Output word number idx of a command of the given mode.
   function automatic item_type seq_item(mode_type mode, logic [IDX_W-1:0] idx);
      item_type it;
      it = '{kind: KIND_UPDATE, bsel: BSEL_ZERO, last: 1'b1};
      case (mode)
         MODE_POWER_DOWN: begin
            case (idx)
               4'd0:    it = '{kind: KIND_UPDATE, bsel: BSEL_ZERO, last: 1'b0};
               4'd1:    it = '{kind: KIND_BYTE, bsel: BSEL_PWDN, last: 1'b0};
               default: it = '{kind: KIND_UPDATE, bsel: BSEL_ZERO, last: 1'b1};
            endcase
         end
         MODE_RESET_SEQ: begin
            case (idx)
               4'd0:    it = '{kind: KIND_RESET, bsel: BSEL_ZERO, last: 1'b0};
               4'd1:    it = '{kind: KIND_WCLK, bsel: BSEL_ZERO, last: 1'b0};
               4'd2:    it = '{kind: KIND_UPDATE, bsel: BSEL_ZERO, last: 1'b0};
               4'd3:    it = '{kind: KIND_BYTE, bsel: BSEL_W0, last: 1'b0};
               4'd4:    it = '{kind: KIND_BYTE, bsel: BSEL_W1, last: 1'b0};
               4'd5:    it = '{kind: KIND_BYTE, bsel: BSEL_W2, last: 1'b0};
               4'd6:    it = '{kind: KIND_BYTE, bsel: BSEL_W3, last: 1'b0};
               4'd7:    it = '{kind: KIND_BYTE, bsel: BSEL_CTRL, last: 1'b0};
               default: it = '{kind: KIND_UPDATE, bsel: BSEL_ZERO, last: 1'b1};
            endcase
         end
         default: begin
            // set frequency and wake-up send the same frame
            case (idx)
               4'd0:    it = '{kind: KIND_BYTE, bsel: BSEL_W0, last: 1'b0};
               4'd1:    it = '{kind: KIND_BYTE, bsel: BSEL_W1, last: 1'b0};
               4'd2:    it = '{kind: KIND_BYTE, bsel: BSEL_W2, last: 1'b0};
               4'd3:    it = '{kind: KIND_BYTE, bsel: BSEL_W3, last: 1'b0};
               4'd4:    it = '{kind: KIND_BYTE, bsel: BSEL_CTRL, last: 1'b0};
               default: it = '{kind: KIND_UPDATE, bsel: BSEL_ZERO, last: 1'b1};
            endcase
         end
      endcase
      return it;
   endfunction

endpackage

// ===== hw/rtl/dtwl_datapath.sv =====
`include "dds_tuning_word_loader_defines.svh"

module dtwl_datapath
   import dtwl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_mode,
   input  logic [FREQ_W-1:0]   req_freq,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [FREQ_W-1:0]   csr_wdata,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [1:0]          rsp_kind,
   output logic [BYTE_W-1:0]   rsp_byte,
   output logic                rsp_last,
   output logic                rsp_ovf
);

   logic [FREQ_W-1:0] ref_ff, ref_in;
   logic              dev_ff, dev_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;
   logic              ovf_ff, ovf_in;
   logic              valid_ff, valid_in;
   kind_type          kind_ff, kind_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              oovf_ff, oovf_in;

   mode_type          mode;
   logic              loads_word;
   logic [FREQ_W-1:0] freq_eff;
   logic              sat;
   logic [FREQ_W:0]   rem_sh;
   logic [FREQ_W:0]   rem_sub;
   logic              qbit;

   assign mode       = mode_type'(req_mode);
   assign loads_word = (mode == MODE_SET_FREQ) || (mode == MODE_RESET_SEQ);
   // reset sequence loads 1 Hz
   assign freq_eff   = (mode == MODE_RESET_SEQ) ? FREQ_W'(1) : req_freq;
   assign sat        = (ref_ff == '0) || (freq_eff >= ref_ff);

   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_sub = rem_sh - {1'b0, ref_ff};
   assign qbit    = (rem_sh >= {1'b0, ref_ff});

   assign sts.sat      = sat;
   assign sts.out_free = !valid_ff || rsp_ready;

   always_comb begin
      ref_in  = ref_ff;
      dev_in  = dev_ff;
      word_in = word_ff;
      rem_in  = rem_ff;
      ovf_in  = ovf_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REF_CLOCK:   ref_in = csr_wdata;
            CSR_DEVICE_TYPE: dev_in = csr_wdata[0];
            default:         ref_in = ref_ff;
         endcase
      end
      if (cmd.capture) begin
         rem_in = freq_eff;
         ovf_in = loads_word && sat;
         if (loads_word && sat) begin
            word_in = '1;
         end
      end else if (cmd.div_step) begin
         // restoring step: the quotient shifts into the word register
         rem_in  = qbit ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
         word_in = {word_ff[WORD_W-2:0], qbit};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      oovf_in  = oovf_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cmd.item.kind;
         last_in  = cmd.item.last;
         oovf_in  = ovf_ff;
         case (cmd.item.bsel)
            BSEL_W0:   byte_in = word_ff[7:0];
            BSEL_W1:   byte_in = word_ff[15:8];
            BSEL_W2:   byte_in = word_ff[23:16];
            BSEL_W3:   byte_in = word_ff[31:24];
            BSEL_CTRL: byte_in = {{(BYTE_W-1){1'b0}}, dev_ff};
            BSEL_PWDN: byte_in = POWER_DOWN_BYTE;
            default:   byte_in = '0;
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff   <= REF_CLOCK_RESET;
         dev_ff   <= 1'b0;
         word_ff  <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         ref_ff   <= ref_in;
         dev_ff   <= dev_in;
         word_ff  <= word_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      oovf_ff <= oovf_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;
   assign rsp_ovf   = oovf_ff;

   `DTWL_ASSERT_NEXT(a_sat_word, cmd.capture && loads_word && sat, word_ff == '1, "saturated word not loaded")
   `DTWL_ASSERT_SAME(a_div_rem_small, cmd.div_step, rem_ff < ref_ff, "divider remainder out of range")
   `DTWL_ASSERT_SAME(a_ovf_non_byte_zero, valid_ff && (kind_ff != KIND_BYTE), byte_ff == '0, "pulse with nonzero byte")

endmodule

// ===== hw/rtl/dtwl_ctrl.sv =====
`include "dds_tuning_word_loader_defines.svh"

module dtwl_ctrl
   import dtwl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_mode,
   output logic       req_tready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   mode_type          mode_ff, mode_in;
   mode_type          req_m;
   logic              accept;

   assign req_m      = mode_type'(req_mode);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      cmd.capture  = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit     = 1'b0;
      cmd.item     = seq_item(mode_ff, cnt_ff[IDX_W-1:0]);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               mode_in     = req_m;
               cnt_in      = '0;
               if (((req_m == MODE_SET_FREQ) || (req_m == MODE_RESET_SEQ)) && !sts.sat) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // hold while the result register is still full
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (cmd.item.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= MODE_SET_FREQ;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
      end
   end

   `DTWL_ASSERT_NEXT(a_accept_busy, accept, !req_tready, "accepted while busy")
   `DTWL_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "result register overwritten")
   `DTWL_ASSERT_NEXT(a_div_start, (state_ff == ST_DIV) && (cnt_ff == '0), state_ff == ST_DIV, "divide cut short")

endmodule

// ===== hw/rtl/dds_tuning_word_loader.sv =====
// Channel  Direction  Handshake                  Payload
// req      in         req_tvalid / req_tready    tuser: mode, tdata: freq_hz
// rsp      out        rsp_tvalid / rsp_tready    tuser: kind, tdata: data_byte, overflow; tlast
// csr      in         csr_we (no wait)           csr_index, csr_wdata
//
// One command at a time: a word is taken only while the controller is idle.
// Set frequency and reset sequence run the restoring divider unless the word saturates, then
// one result word per cycle while the result register is not stalled.
// Power down and wake-up skip the divider.
// A stalled result register holds the sequencer; the final word may wait there while the next
// command is taken. Reset clears the stored tuning word to zero and the registers to defaults.
module dds_tuning_word_loader
   import dtwl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [27:0] freq_hz
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [8] overflow
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [27:0] csr_wdata
);

   cmd_type           cmd;
   sts_type           sts;
   logic [BYTE_W-1:0] rsp_byte;
   logic              rsp_ovf;

   dtwl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dtwl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_mode  (req_tuser),
      .req_freq  (req_tdata[FREQ_W-1:0]),
      .csr_we    (csr_we),
      .csr_index (csr_index[0]),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_kind  (rsp_tuser),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_tlast),
      .rsp_ovf   (rsp_ovf)
   );

   assign rsp_tdata = {7'b0, rsp_ovf, rsp_byte};

endmodule

// ===== tb/sv/dds_tuning_word_loader_tb.sv =====
module dds_tuning_word_loader_tb;
   import dtwl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 26;
   localparam int NUM_ROWS        = 23;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       last;
      logic       overflow;
   } dds_word_type;

   typedef struct packed {
      logic [27:0] ref_cfg;
      logic        dtype;
      mode_type    mode;
      logic [27:0] freq;
      logic        typed;
      logic [31:0] word;
      logic        ovf;
   } stim_row_type;

   // typed rows carry the tuning word and saturation flag that must go out
   localparam stim_row_type DIRECTED_ROWS[NUM_ROWS] = '{
      '{28'd125000000, 1'b0, MODE_WAKE_UP,    28'd0,          1'b1, 32'h0,        1'b0},
      '{28'd125000000, 1'b0, MODE_POWER_DOWN, 28'd0,          1'b1, 32'h0,        1'b0},
      '{28'd125000000, 1'b0, MODE_SET_FREQ,   28'd0,          1'b1, 32'h0,        1'b0},
      '{28'd125000000, 1'b0, MODE_SET_FREQ,   28'hFFFFFFF,    1'b1, 32'hFFFFFFFF, 1'b1},
      '{28'd125000000, 1'b0, MODE_SET_FREQ,   28'd125000000,  1'b1, 32'hFFFFFFFF, 1'b1},
      '{28'd125000000, 1'b0, MODE_SET_FREQ,   28'd124999999,  1'b0, 32'h0,        1'b0},
      '{28'd125000000, 1'b0, MODE_WAKE_UP,    28'd0,          1'b0, 32'h0,        1'b0},
      '{28'd125000000, 1'b0, MODE_RESET_SEQ,  28'd0,          1'b0, 32'h0,        1'b0},
      '{28'd125000000, 1'b0, MODE_SET_FREQ,   28'd1000000,    1'b0, 32'h0,        1'b0},
      '{28'd180000000, 1'b0, MODE_SET_FREQ,   28'h5555555,    1'b0, 32'h0,        1'b0},
      '{28'd180000000, 1'b0, MODE_SET_FREQ,   28'hAAAAAAA,    1'b0, 32'h0,        1'b0},
      '{28'd180000000, 1'b0, MODE_WAKE_UP,    28'hFFFFFFF,    1'b0, 32'h0,        1'b0},
      '{28'd1,         1'b1, MODE_RESET_SEQ,  28'd0,          1'b1, 32'hFFFFFFFF, 1'b1},
      '{28'd1,         1'b1, MODE_SET_FREQ,   28'd0,          1'b1, 32'h0,        1'b0},
      '{28'd1,         1'b1, MODE_WAKE_UP,    28'd0,          1'b1, 32'h0,        1'b0},
      '{28'hFFFFFFF,   1'b1, MODE_SET_FREQ,   28'hFFFFFFE,    1'b0, 32'h0,        1'b0},
      '{28'hFFFFFFF,   1'b1, MODE_SET_FREQ,   28'hFFFFFFF,    1'b1, 32'hFFFFFFFF, 1'b1},
      '{28'hFFFFFFF,   1'b1, MODE_SET_FREQ,   28'd1,          1'b0, 32'h0,        1'b0},
      '{28'hFFFFFFF,   1'b1, MODE_RESET_SEQ,  28'd0,          1'b0, 32'h0,        1'b0},
      '{28'hFFFFFFF,   1'b1, MODE_POWER_DOWN, 28'hFFFFFFF,    1'b0, 32'h0,        1'b0},
      '{28'd0,         1'b0, MODE_SET_FREQ,   28'd0,          1'b1, 32'hFFFFFFFF, 1'b1},
      '{28'd0,         1'b0, MODE_RESET_SEQ,  28'd0,          1'b1, 32'hFFFFFFFF, 1'b1},
      '{28'd0,         1'b0, MODE_WAKE_UP,    28'd0,          1'b1, 32'hFFFFFFFF, 1'b0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [27:0] freq_hz
   logic [1:0]  req_tuser  = '0;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] data_byte, [8] overflow
   logic [1:0]  rsp_tuser;         // [1:0] kind
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [0:0]  csr_index  = '0;
   logic [27:0] csr_wdata  = '0;

   // model of the loader's registers and stored word
   logic [27:0] ref_hz      = 28'd125000000;
   logic        dev_type    = 1'b0;
   logic [31:0] stored_word = '0;

   dds_word_type words_due[$];
   int          errors      = 0;
   int          idle_cycles = 0;
   bit          req_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b1;

   dds_tuning_word_loader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   // floor(freq * 2^32 / ref), saturating when freq reaches the reference or the reference is zero
   function automatic void tuning_word_for(input logic [27:0] freq, output logic [31:0] w,
                                           output logic sat);
      logic [63:0] num;
      logic [63:0] den;
      num = {4'd0, freq, 32'd0};
      den = {36'd0, ref_hz};
      if (ref_hz == '0 || freq >= ref_hz) begin
         w   = '1;
         sat = 1'b1;
      end else begin
         w   = 32'(num / den);
         sat = 1'b0;
      end
   endfunction

   function automatic void push_pulse(input kind_type k, input logic [7:0] b, input logic ovf,
                                      input logic lst);
      words_due.push_back('{kind: k, data_byte: b, last: lst, overflow: ovf});
   endfunction

   function automatic void push_tuning_frame(input logic [31:0] w, input logic ovf);
      for (int i = 0; i < 4; i++) begin
         push_pulse(KIND_BYTE, w[8*i +: 8], ovf, 1'b0);
      end
      push_pulse(KIND_BYTE, {7'd0, dev_type}, ovf, 1'b0);
      push_pulse(KIND_UPDATE, 8'd0, ovf, 1'b1);
   endfunction

   // queue the words one accepted command must produce
   function automatic void predict_command(input mode_type mode, input logic [27:0] freq,
                                           input logic typed, input logic [31:0] typed_word,
                                           input logic typed_ovf);
      logic [31:0] w;
      logic        sat;
      w   = stored_word;
      sat = 1'b0;
      case (mode)
         MODE_SET_FREQ:  tuning_word_for(freq, w, sat);
         MODE_RESET_SEQ: tuning_word_for(28'd1, w, sat);
         default: ;
      endcase
      if (typed) begin
         w   = typed_word;
         sat = typed_ovf;
      end
      case (mode)
         MODE_SET_FREQ: begin
            stored_word = w;
            push_tuning_frame(w, sat);
         end
         MODE_POWER_DOWN: begin
            push_pulse(KIND_UPDATE, 8'd0, 1'b0, 1'b0);
            push_pulse(KIND_BYTE, POWER_DOWN_BYTE, 1'b0, 1'b0);
            push_pulse(KIND_UPDATE, 8'd0, 1'b0, 1'b1);
         end
         MODE_WAKE_UP: begin
            push_tuning_frame(w, 1'b0);
         end
         default: begin
            stored_word = w;
            push_pulse(KIND_RESET, 8'd0, sat, 1'b0);
            push_pulse(KIND_WCLK, 8'd0, sat, 1'b0);
            push_pulse(KIND_UPDATE, 8'd0, sat, 1'b0);
            push_tuning_frame(w, sat);
         end
      endcase
   endfunction

   task automatic send_command(input mode_type mode, input logic [27:0] freq,
                               input logic typed, input logic [31:0] typed_word,
                               input logic typed_ovf);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'd0, freq};
      do @(posedge clock); while (!req_tready);
      predict_command(mode, freq, typed, typed_word, typed_ovf);
   endtask

   // drain every expected word, then give the sequencer time to go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [27:0] hz, input logic dt);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_REF_CLOCK;
      csr_wdata <= hz;
      @(posedge clock);
      csr_index <= CSR_DEVICE_TYPE;
      csr_wdata <= {27'd0, dt};
      @(posedge clock);
      csr_we    <= 1'b0;
      ref_hz   = hz;
      dev_type = dt;
   endtask

   function automatic logic [27:0] pick_ref();
      case ($urandom_range(0, 3))
         0:       return 28'd125000000;
         1:       return 28'd180000000;
         2:       return 28'($urandom_range(1, 32'h0FFFFFFF));
         default: return 28'($urandom_range(1, 1000));
      endcase
   endfunction

   function automatic logic [27:0] pick_freq();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6 && ref_hz > 28'd1) begin
         return 28'($urandom_range(0, 32'(ref_hz) - 1));
      end
      if (r < 9) begin
         return 28'($urandom());
      end
      // right at the saturation threshold
      return ref_hz;
   endfunction

   // result side: random stalls, with some phases holding ready high throughout
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      dds_word_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            $error("unexpected word: kind %0d byte %02h last %0b overflow %0b",
                   rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[8]);
            errors++;
         end else begin
            due = words_due.pop_front();
            if (rsp_tuser != due.kind) begin
               $error("kind: expected %0d, got %0d", due.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] != due.data_byte) begin
               $error("data_byte: expected %02h, got %02h", due.data_byte, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tlast != due.last) begin
               $error("last: expected %0b, got %0b", due.last, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[8] != due.overflow) begin
               $error("overflow: expected %0b, got %0b", due.overflow, rsp_tdata[8]);
               errors++;
            end
         end
      end
   end

   // count cycles with no traffic on any port
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      mode_type mode;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].ref_cfg != ref_hz || DIRECTED_ROWS[i].dtype != dev_type) begin
            apply_settings(DIRECTED_ROWS[i].ref_cfg, DIRECTED_ROWS[i].dtype);
         end
         send_command(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].freq, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].ovf);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       apply_settings(28'hFFFFFFF, 1'b0);
            1:       apply_settings(28'd1, 1'b1);
            default: apply_settings(pick_ref(), 1'($urandom_range(0, 1)));
         endcase
         // vary the gaps and back-pressure: some phases send without request gaps, others never stall results
         req_gaps_on   = (p % 3) != 1;
         rsp_stalls_on = (p % 3) != 2;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 4) begin
               mode = MODE_SET_FREQ;
            end else begin
               mode = mode_type'($urandom_range(1, 3));
            end
            send_command(mode, pick_freq(), 1'b0, 32'h0, 1'b0);
         end
      end

      settle();
      if (errors == 0 && words_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dtwl_pkg.sv
hw/rtl/dtwl_datapath.sv
hw/rtl/dtwl_ctrl.sv
hw/rtl/dds_tuning_word_loader.sv
tb/sv/dds_tuning_word_loader_tb.sv
